@@ rtl/core/tpcb_pkg.sv @@
package tpcb_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int MAX_LINE   = 4096;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int LLW   = $clog2(MAX_LINE);
  localparam int TLW   = 13;

  localparam logic [10:0] COORD_SAT = 11'd2047;

  // Input commands.
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_END  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_SIZE = 2'd0;
  localparam logic [1:0] KIND_PIX  = 2'd1;
  localparam logic [1:0] KIND_DROP = 2'd2;

  // Configuration register indexes.
  localparam logic [7:0] REG_FRAME_WIDTH     = 8'd0;
  localparam logic [7:0] REG_FRAME_HEIGHT    = 8'd1;
  localparam logic [7:0] REG_REPORTED_WIDTH  = 8'd2;
  localparam logic [7:0] REG_REPORTED_HEIGHT = 8'd3;

  // Operations handed from the parser to the frame store.
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_SIZE  = 3'd1;
  localparam logic [2:0] OP_DROP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  typedef struct packed {
    logic [2:0]    kind;
    logic [AW-1:0] addr;
    logic          hit;
    logic [7:0]    r;
    logic [7:0]    g;
    logic [7:0]    b;
    logic [7:0]    a;
  } op_t;

endpackage

@@ rtl/core/tpcb_ifs.sv @@
interface tpcb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;
  logic [8:0] read_x;
  logic [8:0] read_y;
  modport source(output valid, cmd, data_byte, read_x, read_y, input ready);
  modport sink(input valid, cmd, data_byte, read_x, read_y, output ready);
endinterface

interface tpcb_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] width_reply;
  logic [15:0] height_reply;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  modport source(output valid, result_kind, width_reply, height_reply, red_out,
                 green_out, blue_out, input ready);
  modport sink(input valid, result_kind, width_reply, height_reply, red_out,
               green_out, blue_out, output ready);
endinterface

interface tpcb_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/core/text_pixel_command_blender_core.sv @@
// Text pixel command blender core.
// The req channel carries one beat per stream byte (cmd 0), end of
// connection (cmd 1) or display pixel read (cmd 2). Stream bytes build text
// lines: "SIZE\n" answers with the reported size, "PX x y rrggbb[aa]" writes
// or alpha blends one pixel of a 512 x 512 frame store, and a malformed
// PX line drops the connection until the next end of connection.
// The rsp channel returns at most one beat per request beat, in request
// order: a size reply, pixel read data or a connection drop notice.
// The cfg channel writes frame_width, frame_height, reported_width and
// reported_height by index; it is always ready and is meant for idle times.
// A request beat is taken every cycle when the response side keeps up. The
// frame store read and the first stage are loaded when a beat is accepted,
// the second stage then loads the blend multipliers, and the output register
// takes the response from the second stage.
// When rsp stalls, beats without a response keep flowing through; req.ready
// falls once the second internal stage holds a waiting response and the
// first stage holds any beat.
// After reset the frame store is cleared to black one entry a cycle, which
// holds req.ready low until every entry is cleared; configuration writes are
// still taken during that pass.
module text_pixel_command_blender_core (
  input  logic       clk,
  input  logic       rst,
  tpcb_req_if.sink   req,
  tpcb_rsp_if.source rsp,
  tpcb_cfg_if.sink   cfg
);
  import tpcb_pkg::*;

  logic [9:0]  frame_width;
  logic [9:0]  frame_height;
  logic [15:0] reported_width;
  logic [15:0] reported_height;
  logic        accept;
  op_t         op;

  // The register file never pushes back.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= 10'(MAX_WIDTH);
      frame_height    <= 10'(MAX_HEIGHT);
      reported_width  <= '0;
      reported_height <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FRAME_WIDTH:     frame_width     <= cfg.data[9:0];
        REG_FRAME_HEIGHT:    frame_height    <= cfg.data[9:0];
        REG_REPORTED_WIDTH:  reported_width  <= cfg.data;
        REG_REPORTED_HEIGHT: reported_height <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // The parser state advances only on an accepted beat; its decision for
  // that beat travels to the frame store as one operation.
  assign accept = req.valid && req.ready;

  tpcb_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .cmd          (req.cmd),
    .data_byte    (req.data_byte),
    .read_x       (req.read_x),
    .read_y       (req.read_y),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .op           (op)
  );

  tpcb_frame u_frame (
    .clk             (clk),
    .rst             (rst),
    .op_valid        (accept),
    .op              (op),
    .op_ready        (req.ready),
    .reported_width  (reported_width),
    .reported_height (reported_height),
    .rsp             (rsp)
  );

endmodule

@@ rtl/core/tpcb_parser.sv @@
module tpcb_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        cmd,
  input  logic [7:0]        data_byte,
  input  logic [8:0]        read_x,
  input  logic [8:0]        read_y,
  input  logic [9:0]        frame_width,
  input  logic [9:0]        frame_height,
  output tpcb_pkg::op_t     op
);
  import tpcb_pkg::*;

  localparam logic [3:0] PH_HEAD   = 4'd0;
  localparam logic [3:0] PH_XFIRST = 4'd1;
  localparam logic [3:0] PH_XMORE  = 4'd2;
  localparam logic [3:0] PH_YDIG   = 4'd3;
  localparam logic [3:0] PH_THEX   = 4'd4;
  localparam logic [3:0] PH_TREST  = 4'd5;
  localparam logic [3:0] PH_TDONE  = 4'd6;
  localparam logic [3:0] PH_SHORT  = 4'd7;
  localparam logic [3:0] PH_IGNORE = 4'd8;

  localparam logic [2:0] PM_NONE = 3'd0;
  localparam logic [2:0] PM_S    = 3'd1;
  localparam logic [2:0] PM_SI   = 3'd2;
  localparam logic [2:0] PM_SIZ  = 3'd3;
  localparam logic [2:0] PM_SIZE = 3'd4;
  localparam logic [2:0] PM_P    = 3'd5;
  localparam logic [2:0] PM_PX   = 3'd6;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_Z     = 8'h5a;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_X     = 8'h58;

  localparam logic [LLW-1:0] LL_MAX = LLW'(MAX_LINE - 1);

  logic [3:0]     phase;
  logic [2:0]     prefix;
  logic [10:0]    coord_x;
  logic [10:0]    coord_y;
  logic [31:0]    color;
  logic [TLW-1:0] tail_len;
  logic [LLW-1:0] line_len;
  logic           dropped;

  logic [3:0]     ph_next;
  logic [2:0]     pm_next;
  logic [10:0]    cx_next;
  logic [10:0]    cy_next;
  logic [31:0]    cv_next;
  logic [TLW-1:0] tl_next;
  logic           feed_en;
  logic           fin_en;
  logic           fin_drop;
  logic           px_ok;
  logic           wr_hit;
  logic           size_hit;
  logic           digit;
  logic [4:0]     hv;
  logic [7:0]     pr, pg, pb, pa;

  function automatic logic [10:0] dec_acc(input logic [10:0] v, input logic [7:0] c);
    logic [15:0] n;
    n = 16'(v) * 16'd10 + 16'(c[3:0]);
    return (n > 16'(COORD_SAT)) ? COORD_SAT : n[10:0];
  endfunction

  // Bit 4 marks a valid hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] h;
    h = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) h = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      h = {1'b1, c[3:0] + 4'd9};
    return h;
  endfunction

  always_comb begin
    ph_next  = phase;
    pm_next  = prefix;
    cx_next  = coord_x;
    cy_next  = coord_y;
    cv_next  = color;
    tl_next  = tail_len;
    size_hit = 1'b0;
    digit    = data_byte >= 8'h30 && data_byte <= 8'h39;
    hv       = hex_val(data_byte);
    feed_en  = cmd == CMD_BYTE && !dropped && line_len < LL_MAX;
    if (feed_en) begin
      case (phase)
        PH_HEAD: begin
          if (prefix == PM_NONE && data_byte == CH_S) pm_next = PM_S;
          else if (prefix == PM_S && data_byte == CH_I) pm_next = PM_SI;
          else if (prefix == PM_SI && data_byte == CH_Z) pm_next = PM_SIZ;
          else if (prefix == PM_SIZ && data_byte == CH_E) pm_next = PM_SIZE;
          else if (prefix == PM_SIZE && data_byte == CH_LF) begin
            ph_next  = PH_IGNORE;
            size_hit = 1'b1;
          end
          else if (prefix == PM_NONE && data_byte == CH_P) pm_next = PM_P;
          else if (prefix == PM_P && data_byte == CH_X) pm_next = PM_PX;
          else if (prefix == PM_PX && data_byte == CH_SPACE) ph_next = PH_XFIRST;
          else ph_next = PH_IGNORE;
        end
        PH_XFIRST: begin
          if (digit) begin
            cx_next = {7'd0, data_byte[3:0]};
            ph_next = PH_XMORE;
          end else if (data_byte == CH_NUL) begin
            ph_next = PH_SHORT;
          end else begin
            // An empty x run: this character opens the tail directly.
            tl_next = TLW'(1);
            ph_next = PH_THEX;
          end
        end
        PH_XMORE: begin
          if (digit) cx_next = dec_acc(coord_x, data_byte);
          else if (data_byte == CH_NUL) ph_next = PH_SHORT;
          else ph_next = PH_YDIG;
        end
        PH_YDIG: begin
          if (digit) cy_next = dec_acc(coord_y, data_byte);
          else if (data_byte == CH_NUL) ph_next = PH_SHORT;
          else begin
            tl_next = TLW'(1);
            ph_next = PH_THEX;
          end
        end
        PH_THEX: begin
          if (data_byte == CH_NUL) ph_next = PH_TDONE;
          else begin
            tl_next = tail_len + TLW'(1);
            if (hv[4]) cv_next = {color[27:0], hv[3:0]};
            else ph_next = PH_TREST;
          end
        end
        PH_TREST: begin
          if (data_byte == CH_NUL) ph_next = PH_TDONE;
          else tl_next = tail_len + TLW'(1);
        end
        default: begin
        end
      endcase
    end

    fin_en = !dropped && ((cmd == CMD_BYTE && data_byte == CH_LF) ||
                          (cmd == CMD_END && line_len != '0));
    fin_drop = 1'b0;
    px_ok    = 1'b0;
    pr = 8'd0; pg = 8'd0; pb = 8'd0; pa = 8'd0;
    if (fin_en) begin
      if (ph_next == PH_HEAD || ph_next == PH_IGNORE) begin
        fin_drop = 1'b0;
      end else if (ph_next < PH_THEX || ph_next == PH_SHORT) begin
        fin_drop = 1'b1;
      end else if (tl_next == TLW'(8)) begin
        pr = cv_next[23:16]; pg = cv_next[15:8]; pb = cv_next[7:0]; pa = 8'hff;
        px_ok = 1'b1;
      end else if (tl_next == TLW'(10)) begin
        pr = cv_next[31:24]; pg = cv_next[23:16]; pb = cv_next[15:8]; pa = cv_next[7:0];
        px_ok = 1'b1;
      end else begin
        fin_drop = 1'b1;
      end
    end
    wr_hit = px_ok && (cx_next < {1'b0, frame_width}) && (cy_next < {1'b0, frame_height}) &&
             ({2'd0, cx_next} < 13'(MAX_WIDTH)) && ({2'd0, cy_next} < 13'(MAX_HEIGHT));

    op.r = pr; op.g = pg; op.b = pb; op.a = pa;
    op.kind = OP_NONE;
    op.hit  = 1'b0;
    op.addr = AW'(32'(cy_next) * 32'(MAX_WIDTH) + 32'(cx_next));
    case (cmd)
      CMD_READ: begin
        op.kind = OP_READ;
        op.hit  = (32'(read_x) < 32'(MAX_WIDTH)) && (32'(read_y) < 32'(MAX_HEIGHT));
        op.addr = op.hit ? AW'(32'(read_y) * 32'(MAX_WIDTH) + 32'(read_x)) : '0;
      end
      CMD_END, CMD_BYTE: begin
        if (fin_drop) op.kind = OP_DROP;
        else if (wr_hit) op.kind = OP_WRITE;
        else if (size_hit) op.kind = OP_SIZE;
      end
      default: op.kind = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEAD;
      prefix   <= PM_NONE;
      coord_x  <= '0;
      coord_y  <= '0;
      color    <= '0;
      tail_len <= '0;
      line_len <= '0;
      dropped  <= 1'b0;
    end else if (accept) begin
      if (cmd == CMD_END || (cmd == CMD_BYTE && !dropped && data_byte == CH_LF)) begin
        phase    <= PH_HEAD;
        prefix   <= PM_NONE;
        coord_x  <= '0;
        coord_y  <= '0;
        color    <= '0;
        tail_len <= '0;
        line_len <= '0;
        dropped  <= (cmd == CMD_BYTE) && fin_drop;
      end else if (cmd == CMD_BYTE && !dropped) begin
        phase    <= ph_next;
        prefix   <= pm_next;
        coord_x  <= cx_next;
        coord_y  <= cy_next;
        color    <= cv_next;
        tail_len <= tl_next;
        line_len <= line_len + LLW'(feed_en);
      end
    end
  end

endmodule

@@ rtl/core/tpcb_frame.sv @@
module tpcb_frame (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  input  tpcb_pkg::op_t op,
  output logic          op_ready,
  input  logic [15:0]   reported_width,
  input  logic [15:0]   reported_height,
  tpcb_rsp_if.source    rsp
);
  import tpcb_pkg::*;

  logic [23:0] mem [DEPTH];
  logic [23:0] rdata;

  logic          clearing;
  logic [AW-1:0] clr_addr;

  logic          s1_v;
  op_t           s1_op;
  logic          s1_go;
  logic          s1_free;
  logic [23:0]   s1_pix;

  logic          s2_v;
  logic [2:0]    s2_kind;
  logic [AW-1:0] s2_addr;
  logic [15:0]   s2_po [3];
  logic [15:0]   s2_pn [3];
  logic [23:0]   s2_pix;
  logic [23:0]   s2_final;
  logic          s2_res;
  logic          s2_go;
  logic          s2_free;
  logic          s2_wr;

  logic          w_v;
  logic [AW-1:0] w_addr;
  logic [23:0]   w_data;

  logic          out_free;

  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] s;
    s = 17'(v) + 17'd1 + 17'(v[15:8]);
    return s[15:8];
  endfunction

  assign out_free = !rsp.valid || rsp.ready;
  assign s2_res   = s2_kind == OP_SIZE || s2_kind == OP_DROP || s2_kind == OP_READ;
  assign s2_go    = s2_v && (!s2_res || out_free);
  assign s2_free  = !s2_v || s2_go;
  assign s2_wr    = s2_go && s2_kind == OP_WRITE;
  assign s1_go    = s1_v && s2_free;
  assign s1_free  = !s1_v || s1_go;
  assign op_ready = !clearing && s1_free;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_final[8*i +: 8] = div255(s2_po[i]) + div255(s2_pn[i]);
    end
  end

  // A read sees the writes still in flight behind its own memory access.
  always_comb begin
    s1_pix = rdata;
    if (s2_v && s2_kind == OP_WRITE && s2_addr == s1_op.addr) s1_pix = s2_final;
    else if (w_v && w_addr == s1_op.addr) s1_pix = w_data;
    if (!s1_op.hit) s1_pix = '0;
  end

  always_ff @(posedge clk) begin
    if (op_valid && (op.kind == OP_WRITE || op.kind == OP_READ)) rdata <= mem[op.addr];
  end

  always_ff @(posedge clk) begin
    if (clearing) mem[clr_addr] <= '0;
    else if (s2_wr) mem[s2_addr] <= s2_final;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      w_v      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(DEPTH - 1)) clearing <= 1'b0;
      end

      if (op_valid) begin
        s1_v  <= 1'b1;
        s1_op <= op;
      end else if (s1_go) begin
        s1_v <= 1'b0;
      end

      if (s1_go) begin
        s2_v    <= 1'b1;
        s2_kind <= s1_op.kind;
        s2_addr <= s1_op.addr;
        s2_pix  <= s1_pix;
        // Pixel lines are at least eleven beats apart, so the raw read
        // already holds every earlier write to the entry.
        s2_po[2] <= 16'(rdata[23:16]) * 16'(8'hff - s1_op.a);
        s2_po[1] <= 16'(rdata[15:8])  * 16'(8'hff - s1_op.a);
        s2_po[0] <= 16'(rdata[7:0])   * 16'(8'hff - s1_op.a);
        s2_pn[2] <= 16'(s1_op.r) * 16'(s1_op.a);
        s2_pn[1] <= 16'(s1_op.g) * 16'(s1_op.a);
        s2_pn[0] <= 16'(s1_op.b) * 16'(s1_op.a);
      end else if (s2_go) begin
        s2_v <= 1'b0;
      end

      if (s2_wr) begin
        w_v    <= 1'b1;
        w_addr <= s2_addr;
        w_data <= s2_final;
      end

      if (s2_go && s2_res) begin
        rsp.valid        <= 1'b1;
        rsp.width_reply  <= '0;
        rsp.height_reply <= '0;
        rsp.red_out      <= '0;
        rsp.green_out    <= '0;
        rsp.blue_out     <= '0;
        case (s2_kind)
          OP_SIZE: begin
            rsp.result_kind  <= KIND_SIZE;
            rsp.width_reply  <= reported_width;
            rsp.height_reply <= reported_height;
          end
          OP_READ: begin
            rsp.result_kind <= KIND_PIX;
            rsp.red_out     <= s2_pix[23:16];
            rsp.green_out   <= s2_pix[15:8];
            rsp.blue_out    <= s2_pix[7:0];
          end
          default: rsp.result_kind <= KIND_DROP;
        endcase
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/tpcb_checker.sv @@
module tpcb_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  result_kind,
  input logic [15:0] width_reply,
  input logic [15:0] height_reply,
  input logic [7:0]  red_out,
  input logic [7:0]  green_out,
  input logic [7:0]  blue_out
);
  import tpcb_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_kind) &&
      $stable(width_reply) && $stable(height_reply) && $stable(red_out) &&
      $stable(green_out) && $stable(blue_out))
    else $error("response changed while stalled");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !req_ready)
    else $error("request taken during frame clear");

  a_size_only_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && result_kind != KIND_SIZE |-> width_reply == '0 && height_reply == '0)
    else $error("size fields set on a non-size response");

  a_pix_only_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && result_kind != KIND_PIX |->
      red_out == '0 && green_out == '0 && blue_out == '0)
    else $error("colour fields set on a non-pixel response");

endmodule

bind text_pixel_command_blender_core tpcb_checker u_tpcb_checker (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .result_kind  (rsp.result_kind),
  .width_reply  (rsp.width_reply),
  .height_reply (rsp.height_reply),
  .red_out      (rsp.red_out),
  .green_out    (rsp.green_out),
  .blue_out     (rsp.blue_out)
);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import tpcb_pkg::*;

  // Generous cycle budget: it covers the clearing pass after reset, and every beat
  // may meet a random gap on the request side and a stall on the response side.
  localparam int CYCLE_LIMIT = 3_000_000;

  // The one command code the core ignores.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One response beat as the core presents it.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
  } reply_t;

  // One request beat. A row with a typed reply carries its own expectation;
  // all others are checked against the line parser model below.
  typedef struct {
    logic [1:0] cmd;
    logic [7:0] db;
    logic [8:0] rx;
    logic [8:0] ry;
    bit         typed;
    bit         has;
    reply_t     rep;
  } beat_t;

  // Parse phases of the line model.
  typedef enum int {
    ST_HEAD, ST_XFIRST, ST_XMORE, ST_YDIG, ST_THEX, ST_TREST, ST_TDONE, ST_SHORT, ST_IGNORE
  } phase_t;

  logic clk;
  logic rst;

  tpcb_req_if req_if();
  tpcb_rsp_if rsp_if();
  tpcb_cfg_if cfg_if();

  text_pixel_command_blender_core u_top (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .rsp(rsp_if.source),
    .cfg(cfg_if.sink)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Model copy of the registers and the parse state.
  logic [9:0]  m_fw;
  logic [9:0]  m_fh;
  logic [15:0] m_rw;
  logic [15:0] m_rh;
  phase_t      m_ph;
  int unsigned m_pm;
  int unsigned m_cx;
  int unsigned m_cy;
  logic [31:0] m_color;
  int unsigned m_tail;
  int unsigned m_llen;
  bit          m_dropped;
  logic [23:0] m_pixels[int];

  beat_t  stim_q[$];
  reply_t reply_q[$];
  int     fail_count;
  int     beats_sent;
  int     kind_seen[4];
  bit     quiet;
  int     cycle_count;

  // The color and coordinate scratch values are cleared with the line.
  function automatic void clear_line();
    m_ph = ST_HEAD;
    m_pm = 0;
    m_cx = 0;
    m_cy = 0;
    m_color = '0;
    m_tail = 0;
    m_llen = 0;
  endfunction

  function automatic int unsigned dec_step(int unsigned v, logic [7:0] c);
    int unsigned n;
    n = v * 10 + (c - 8'd48);
    return (n > COORD_SAT) ? 2047 : n;
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void y_byte(logic [7:0] c);
    if (c >= "0" && c <= "9") m_cy = dec_step(m_cy, c);
    else if (c == 8'd0) m_ph = ST_SHORT;
    else begin
      m_tail = 1;
      m_ph = ST_THEX;
    end
  endfunction

  // Advances the parser by one stored byte; returns 1 when a size reply is due.
  function automatic bit parse_byte(logic [7:0] c);
    bit digit;
    int hv;
    digit = (c >= "0" && c <= "9");
    case (m_ph)
      ST_HEAD: begin
        if (m_pm == 0 && c == "S") m_pm = 1;
        else if (m_pm == 1 && c == "I") m_pm = 2;
        else if (m_pm == 2 && c == "Z") m_pm = 3;
        else if (m_pm == 3 && c == "E") m_pm = 4;
        else if (m_pm == 4 && c == 8'h0a) begin
          m_ph = ST_IGNORE;
          return 1'b1;
        end
        else if (m_pm == 0 && c == "P") m_pm = 5;
        else if (m_pm == 5 && c == "X") m_pm = 6;
        else if (m_pm == 6 && c == " ") m_ph = ST_XFIRST;
        else m_ph = ST_IGNORE;
      end
      ST_XFIRST: begin
        if (digit) begin
          m_cx = c - "0";
          m_ph = ST_XMORE;
        end
        else if (c == 8'd0) m_ph = ST_SHORT;
        else begin
          m_ph = ST_YDIG;
          y_byte(c);
        end
      end
      ST_XMORE: begin
        if (digit) m_cx = dec_step(m_cx, c);
        else if (c == 8'd0) m_ph = ST_SHORT;
        else m_ph = ST_YDIG;
      end
      ST_YDIG: y_byte(c);
      ST_THEX: begin
        if (c == 8'd0) m_ph = ST_TDONE;
        else begin
          m_tail++;
          hv = hex_digit(c);
          if (hv >= 0) m_color = {m_color[27:0], 4'(hv)};
          else m_ph = ST_TREST;
        end
      end
      ST_TREST: begin
        if (c == 8'd0) m_ph = ST_TDONE;
        else m_tail++;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic logic [7:0] mix(int unsigned old, int unsigned c, int unsigned a);
    return 8'((old * (255 - a)) / 255 + (c * a) / 255);
  endfunction

  // Evaluates a finished line, writing the frame store; returns 1 on a drop.
  function automatic bit close_line();
    logic [7:0]  r, g, b, a;
    logic [23:0] old;
    int          idx;
    if (m_ph == ST_HEAD || m_ph == ST_IGNORE) return 1'b0;
    if (m_ph < ST_THEX || m_ph == ST_SHORT) return 1'b1;
    if (m_tail == 8) begin
      {r, g, b} = m_color[23:0];
      a = 8'hff;
    end
    else if (m_tail == 10) {r, g, b, a} = m_color;
    else return 1'b1;
    if (m_cx >= m_fw || m_cy >= m_fh || m_cx >= MAX_WIDTH || m_cy >= MAX_HEIGHT)
      return 1'b0;
    idx = m_cy * MAX_WIDTH + m_cx;
    if (a != 8'hff) begin
      old = m_pixels.exists(idx) ? m_pixels[idx] : 24'h0;
      r = mix(old[23:16], r, a);
      g = mix(old[15:8], g, a);
      b = mix(old[7:0], b, a);
    end
    m_pixels[idx] = {r, g, b};
    return 1'b0;
  endfunction

  // Predicts the reply for one accepted request beat.
  function automatic bit predict_reply(beat_t bt, output reply_t rp);
    bit size_due;
    bit drop;
    int idx;
    rp = '0;
    size_due = 1'b0;
    drop = 1'b0;
    if (bt.cmd == CMD_READ) begin
      idx = bt.ry * MAX_WIDTH + bt.rx;
      rp.kind = KIND_PIX;
      if (m_pixels.exists(idx)) {rp.r, rp.g, rp.b} = m_pixels[idx];
      return 1'b1;
    end
    if (bt.cmd == CMD_END) begin
      if (!m_dropped && m_llen > 0) drop = close_line();
      clear_line();
      m_dropped = 1'b0;
      rp.kind = KIND_DROP;
      return drop;
    end
    if (bt.cmd != CMD_BYTE || m_dropped) return 1'b0;
    if (m_llen < MAX_LINE - 1) begin
      size_due = parse_byte(bt.db);
      m_llen++;
    end
    if (bt.db == 8'h0a) begin
      drop = close_line();
      clear_line();
      if (drop) begin
        m_dropped = 1'b1;
        rp.kind = KIND_DROP;
        return 1'b1;
      end
    end
    if (size_due) begin
      rp.kind = KIND_SIZE;
      rp.w = m_rw;
      rp.h = m_rh;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Request side: hold a beat until accepted, then model it and present the next.
  int    req_gap;
  beat_t cur_beat;

  always @(posedge clk) begin
    reply_t pr;
    bit     got;
    if (req_if.valid && req_if.ready) begin
      got = predict_reply(cur_beat, pr);
      beats_sent++;
      if (cur_beat.typed) begin
        if (got != cur_beat.has) begin
          $error("reply presence: expected %0d actual %0d", cur_beat.has, got);
          fail_count++;
        end
        if (cur_beat.has) reply_q.push_back(cur_beat.rep);
      end
      else if (got) reply_q.push_back(pr);
    end
    if (!req_if.valid || req_if.ready) begin
      if (req_gap == 0 && !quiet && $urandom_range(0, 9) == 0)
        req_gap = $urandom_range(1, 12);
      if (req_gap > 0) begin
        req_gap--;
        req_if.valid <= 1'b0;
      end
      else if (stim_q.size() > 0) begin
        cur_beat = stim_q.pop_front();
        req_if.valid <= 1'b1;
        req_if.cmd <= cur_beat.cmd;
        req_if.data_byte <= cur_beat.db;
        req_if.read_x <= cur_beat.rx;
        req_if.read_y <= cur_beat.ry;
      end
      else req_if.valid <= 1'b0;
    end
  end

  // Response side: random stall bursts, field by field check against the oldest expectation.
  int rsp_stall;

  always @(posedge clk) begin
    reply_t ex;
    if (rsp_if.valid && rsp_if.ready) begin
      if (reply_q.size() == 0) begin
        $error("reply beat with nothing expected: kind %0d", rsp_if.result_kind);
        fail_count++;
      end
      else begin
        ex = reply_q.pop_front();
        kind_seen[ex.kind]++;
        if (rsp_if.result_kind !== ex.kind) begin
          $error("result_kind: expected %0d actual %0d", ex.kind, rsp_if.result_kind);
          fail_count++;
        end
        if (rsp_if.width_reply !== ex.w) begin
          $error("width_reply: expected %0d actual %0d", ex.w, rsp_if.width_reply);
          fail_count++;
        end
        if (rsp_if.height_reply !== ex.h) begin
          $error("height_reply: expected %0d actual %0d", ex.h, rsp_if.height_reply);
          fail_count++;
        end
        if (rsp_if.red_out !== ex.r) begin
          $error("red_out: expected %0h actual %0h", ex.r, rsp_if.red_out);
          fail_count++;
        end
        if (rsp_if.green_out !== ex.g) begin
          $error("green_out: expected %0h actual %0h", ex.g, rsp_if.green_out);
          fail_count++;
        end
        if (rsp_if.blue_out !== ex.b) begin
          $error("blue_out: expected %0h actual %0h", ex.b, rsp_if.blue_out);
          fail_count++;
        end
      end
    end
    if (rsp_stall == 0 && !quiet && $urandom_range(0, 9) == 0)
      rsp_stall = $urandom_range(1, 12);
    if (rsp_stall > 0) begin
      rsp_stall--;
      rsp_if.ready <= 1'b0;
    end
    else rsp_if.ready <= 1'b1;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
               reply_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus builders.
  function automatic void push_beat(logic [1:0] cmd, logic [7:0] db, logic [8:0] rx,
                                    logic [8:0] ry);
    beat_t bt;
    bt.cmd = cmd;
    bt.db = db;
    bt.rx = rx;
    bt.ry = ry;
    bt.typed = 1'b0;
    bt.has = 1'b0;
    bt.rep = '0;
    stim_q.push_back(bt);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_beat(CMD_BYTE, s[i], 9'($urandom), 9'($urandom));
  endfunction

  function automatic string hex_run(int n);
    string digits;
    string s;
    digits = "0123456789abcdefABCDEF";
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(digits[$urandom_range(0, 21)])};
    return s;
  endfunction

  // Coordinates mostly in a small corner so that reads and blends meet written
  // pixels; now and then out of range or long enough to saturate.
  function automatic string coord_text();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return $sformatf("%0d", $urandom_range(0, 7));
    if (pick < 17) return $sformatf("%0d", $urandom_range(0, 600));
    if (pick < 18) return $sformatf("%0d", $urandom_range(512, 2100));
    if (pick < 19) return $sformatf("%0d%0d", $urandom_range(1, 9), $urandom);
    return "";
  endfunction

  function automatic string sep_text();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return " ";
    do c = 8'($urandom); while (c == 8'd0 || (c >= "0" && c <= "9"));
    return string'(c);
  endfunction

  // One stimulus unit; returns the number of beats pushed.
  function automatic int push_unit();
    int q_start;
    int pick;
    int n;
    q_start = stim_q.size();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      push_text({"PX ", coord_text(), sep_text(), coord_text(), sep_text(),
                 hex_run($urandom_range(0, 1) ? 6 : 8), "\n"});
    end
    else if (pick < 60) begin
      if ($urandom_range(0, 2) == 0)
        push_beat(CMD_READ, 8'($urandom), 9'($urandom), 9'($urandom));
      else
        push_beat(CMD_READ, 8'($urandom), 9'($urandom_range(0, 7)),
                  9'($urandom_range(0, 7)));
    end
    else if (pick < 67) push_text("SIZE\n");
    else if (pick < 74) push_beat(CMD_END, 8'($urandom), 9'($urandom), 9'($urandom));
    else if (pick < 86) begin
      // Broken lines: bad color length, line ending early, or a zero byte.
      case ($urandom_range(0, 3))
        0: push_text({"PX ", coord_text(), " ", coord_text(), " ",
                      hex_run($urandom_range(0, 12)), "\n"});
        1: begin
          if ($urandom_range(0, 1)) push_text({"PX ", coord_text(), "\n"});
          else push_text({"PX ", coord_text()});
        end
        2: begin
          push_text({"PX ", coord_text(), " ", coord_text(), " ", hex_run($urandom_range(0, 8))});
          push_beat(CMD_BYTE, 8'd0, 9'd0, 9'd0);
          push_text({hex_run($urandom_range(0, 3)), "\n"});
        end
        default: push_text({"PX ", hex_run($urandom_range(1, 9)), "zz\n"});
      endcase
      if ($urandom_range(0, 9) < 7) push_beat(CMD_END, 8'($urandom), 9'($urandom), 9'($urandom));
    end
    else if (pick < 95) begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) push_beat(CMD_BYTE, 8'($urandom), 9'($urandom), 9'($urandom));
      if ($urandom_range(0, 1)) push_text("\n");
    end
    else push_beat(CMD_UNUSED, 8'($urandom), 9'($urandom), 9'($urandom));
    return stim_q.size() - q_start;
  endfunction

  // Waits until every queued beat is taken and every reply has come back, plus
  // a margin for writes that are still in the pipeline without a reply.
  task automatic drain();
    @(posedge clk);
    while (stim_q.size() > 0 || req_if.valid || reply_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Writes all four registers back to back; valid only falls after the last.
  task automatic write_regs(logic [15:0] fw, logic [15:0] fh, logic [15:0] rw, logic [15:0] rh);
    logic [15:0] vals[4];
    vals = '{fw, fh, rw, rh};
    for (int i = 0; i < 4; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= 8'(i);
      cfg_if.data <= vals[i];
      do @(posedge clk); while (!cfg_if.ready);
      case (8'(i))
        REG_FRAME_WIDTH:    m_fw = vals[i][9:0];
        REG_FRAME_HEIGHT:   m_fh = vals[i][9:0];
        REG_REPORTED_WIDTH: m_rw = vals[i];
        default:            m_rh = vals[i];
      endcase
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_phase(int count);
    int pushed;
    pushed = 0;
    while (pushed < count) pushed += push_unit();
    drain();
  endtask

  // Directed table: one row per command or text line. The typed reply, where
  // present, belongs to the last beat of the row.
  typedef struct {
    logic [1:0] cmd;
    string      text;
    logic [8:0] rx;
    logic [8:0] ry;
    bit         typed;
    bit         has;
    reply_t     rep;
  } row_t;

  row_t rows[9];

  initial begin
    row_t  rw;
    beat_t bt;
    fail_count = 0;
    beats_sent = 0;
    quiet = 1'b0;
    req_gap = 0;
    rsp_stall = 0;
    cycle_count = 0;
    kind_seen = '{default: 0};
    req_if.valid = 1'b0;
    req_if.cmd = CMD_BYTE;
    req_if.data_byte = '0;
    req_if.read_x = '0;
    req_if.read_y = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    m_fw = 10'd512;
    m_fh = 10'd512;
    m_rw = '0;
    m_rh = '0;
    m_dropped = 1'b0;
    clear_line();

    rows[0] = '{CMD_READ, "", 9'd0, 9'd0, 1'b1, 1'b1,
                '{KIND_PIX, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0}};
    rows[1] = '{CMD_READ, "", 9'd511, 9'd511, 1'b1, 1'b1,
                '{KIND_PIX, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0}};
    rows[2] = '{CMD_BYTE, "SIZE\n", 9'd0, 9'd0, 1'b1, 1'b1,
                '{KIND_SIZE, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0}};
    rows[3] = '{CMD_BYTE, "PX 5 7 ff00ff\n", 9'd0, 9'd0, 1'b1, 1'b0, '0};
    rows[4] = '{CMD_READ, "", 9'd5, 9'd7, 1'b1, 1'b1,
                '{KIND_PIX, 16'd0, 16'd0, 8'hff, 8'h00, 8'hff}};
    rows[5] = '{CMD_BYTE, "PX 1\n", 9'd0, 9'd0, 1'b1, 1'b1,
                '{KIND_DROP, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0}};
    rows[6] = '{CMD_BYTE, "S", 9'd0, 9'd0, 1'b1, 1'b0, '0};
    rows[7] = '{CMD_UNUSED, "", 9'd0, 9'd0, 1'b1, 1'b0, '0};
    rows[8] = '{CMD_END, "", 9'd0, 9'd0, 1'b1, 1'b0, '0};

    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset register values.
    foreach (rows[i]) begin
      rw = rows[i];
      if (rw.cmd == CMD_BYTE) push_text(rw.text);
      else push_beat(rw.cmd, 8'hff, rw.rx, rw.ry);
      bt = stim_q[$];
      bt.typed = rw.typed;
      bt.has = rw.has;
      bt.rep = rw.rep;
      stim_q[$] = bt;
    end
    drain();

    // Random phases, each with its own register setting; the drain before each
    // write also makes the sender wait for every outstanding reply.
    write_regs(16'd512, 16'd512, 16'hffff, 16'hffff);
    random_phase(190);
    write_regs(16'd1, 16'd1, 16'd0, 16'hffff);
    random_phase(150);
    write_regs(16'd6, 16'd3, 16'h1234, 16'h0);
    random_phase(180);
    write_regs(16'd300, 16'd512, 16'($urandom), 16'($urandom));
    random_phase(200);
    write_regs(16'd512, 16'd512, 16'($urandom), 16'($urandom));
    quiet = 1'b1;
    random_phase(200);

    $display("summary: %0d request beats, replies size %0d pixel %0d drop %0d",
             beats_sent, kind_seen[0], kind_seen[1], kind_seen[2]);
    $display("summary: five register settings incl. 1x1 and 512x512 frames, %0d cycles",
             cycle_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end
    else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
